// ===== sv/disjoint_set_union_find_defines.svh =====
`ifndef DISJOINT_SET_UNION_FIND_DEFINES_SVH
`define DISJOINT_SET_UNION_FIND_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define DSUF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define DSUF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/dsuf_pkg.sv =====
package dsuf_pkg;

	localparam int ELEM_W         = 10;
	localparam int SIZE_W         = 11;
	localparam int NCMP_W         = 17;
	localparam int ELEM_COUNT     = 1 << ELEM_W;
	localparam int N_ELEMENTS_DEF = 1024;

	localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};

	localparam logic [1:0] KIND_FIND_C = 2'd0;
	localparam logic [1:0] KIND_FIND   = 2'd1;
	localparam logic [1:0] KIND_UNION  = 2'd2;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ELEM_W-1:0] elem_a;
		logic [ELEM_W-1:0] elem_b;
	} req_t;

	typedef struct packed {
		logic [ELEM_W-1:0] root;
		logic [SIZE_W-1:0] root_size;
	} res_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_LOOKUP,
		ST_COMP,
		ST_UA,
		ST_UB,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		RD_IN,
		RD_A,
		RD_B,
		RD_P
	} rsel_t;

	typedef enum logic [1:0] {
		X_HOLD,
		X_P,
		X_A
	} xop_t;

	typedef enum logic {
		PW_UNION,
		PW_COMP
	} pwsel_t;

	typedef enum logic [1:0] {
		RES_OOR,
		RES_SZA,
		RES_WALK,
		RES_UNION
	} resop_t;

	typedef struct packed {
		logic   load;
		rsel_t  rsel;
		xop_t   x_op;
		logic   cnt_inc;
		logic   sa_ld;
		logic   pwe;
		pwsel_t pw_sel;
		logic   swe;
		logic   clr;
		logic   res_ld;
		resop_t res_op;
	} cmd_t;

	typedef struct packed {
		logic a_ok;
		logic union_go;
		logic p_root;
		logic p_oor;
		logic cnt_last;
		logic x_root;
		logic clr_last;
	} stat_t;

endpackage

// ===== sv/disjoint_set_union_find.sv =====
// channel   | ports                 | transfer
// ----------+-----------------------+-----------------------------------------
// request   | start, busy, req      | edge with start high and busy low
// result    | done, res             | edge ending the one cycle done is high
//
// Union: UA, then UB if b is in range and not a. Element out of range: DONE.
// Find: walks the chain link by link, then rewrites each link when
// compressing, then the result cycle; one parent-memory read per link.
// Reset runs a clearing pass over min(N_ELEMENTS, 1024) entries with busy high.
// The result is not held: done is high for one cycle, busy high until after.
module disjoint_set_union_find #(
	parameter int N_ELEMENTS = dsuf_pkg::N_ELEMENTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  dsuf_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output dsuf_pkg::res_t res
);

	dsuf_pkg::cmd_t  cmd;
	dsuf_pkg::stat_t stat;

	dsuf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (req.kind),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	dsuf_dpath #(
		.N_ELEMENTS (N_ELEMENTS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.res    (res)
	);

endmodule

// ===== sv/dsuf_ctrl.sv =====
module dsuf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [1:0]      kind,
	input  dsuf_pkg::stat_t stat,
	output dsuf_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            done
);

	dsuf_pkg::state_t state_q, state_d;
	logic             cmp_q, cmp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsuf_pkg::ST_CLEAR;
			cmp_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cmp_q   <= cmp_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmp_d       = cmp_q;
		cmd         = '0;
		cmd.rsel    = dsuf_pkg::RD_IN;
		cmd.x_op    = dsuf_pkg::X_HOLD;
		cmd.pw_sel  = dsuf_pkg::PW_UNION;
		cmd.res_op  = dsuf_pkg::RES_OOR;
		busy        = 1'b1;
		done        = 1'b0;
		unique case (state_q)
			dsuf_pkg::ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) begin
					state_d = dsuf_pkg::ST_IDLE;
				end
			end
			dsuf_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					cmd.rsel = dsuf_pkg::RD_IN;
					if (!stat.a_ok) begin
						cmd.res_ld = 1'b1;
						cmd.res_op = dsuf_pkg::RES_OOR;
						state_d    = dsuf_pkg::ST_DONE;
					end else if (kind == dsuf_pkg::KIND_UNION) begin
						state_d = dsuf_pkg::ST_UA;
					end else begin
						cmp_d   = (kind == dsuf_pkg::KIND_FIND_C);
						state_d = dsuf_pkg::ST_WALK;
					end
				end
			end
			dsuf_pkg::ST_WALK: begin
				if (stat.p_root) begin
					cmd.res_ld = 1'b1;
					cmd.res_op = dsuf_pkg::RES_WALK;
					if (cmp_q) begin
						cmd.rsel = dsuf_pkg::RD_A;
						cmd.x_op = dsuf_pkg::X_A;
						state_d  = dsuf_pkg::ST_COMP;
					end else begin
						state_d = dsuf_pkg::ST_DONE;
					end
				end else if (stat.p_oor) begin
					cmd.res_ld = 1'b1;
					cmd.res_op = dsuf_pkg::RES_WALK;
					state_d    = dsuf_pkg::ST_DONE;
				end else if (stat.cnt_last) begin
					cmd.rsel = dsuf_pkg::RD_P;
					cmd.x_op = dsuf_pkg::X_P;
					state_d  = dsuf_pkg::ST_LOOKUP;
				end else begin
					cmd.rsel    = dsuf_pkg::RD_P;
					cmd.x_op    = dsuf_pkg::X_P;
					cmd.cnt_inc = 1'b1;
				end
			end
			dsuf_pkg::ST_LOOKUP: begin
				cmd.res_ld = 1'b1;
				cmd.res_op = dsuf_pkg::RES_WALK;
				state_d    = dsuf_pkg::ST_DONE;
			end
			dsuf_pkg::ST_COMP: begin
				if (stat.x_root) begin
					state_d = dsuf_pkg::ST_DONE;
				end else begin
					cmd.pwe    = 1'b1;
					cmd.pw_sel = dsuf_pkg::PW_COMP;
					if (stat.p_oor) begin
						state_d = dsuf_pkg::ST_DONE;
					end else begin
						cmd.rsel = dsuf_pkg::RD_P;
						cmd.x_op = dsuf_pkg::X_P;
					end
				end
			end
			dsuf_pkg::ST_UA: begin
				if (stat.union_go) begin
					cmd.sa_ld = 1'b1;
					cmd.rsel  = dsuf_pkg::RD_B;
					state_d   = dsuf_pkg::ST_UB;
				end else begin
					cmd.res_ld = 1'b1;
					cmd.res_op = dsuf_pkg::RES_SZA;
					state_d    = dsuf_pkg::ST_DONE;
				end
			end
			dsuf_pkg::ST_UB: begin
				cmd.pwe    = 1'b1;
				cmd.pw_sel = dsuf_pkg::PW_UNION;
				cmd.swe    = 1'b1;
				cmd.res_ld = 1'b1;
				cmd.res_op = dsuf_pkg::RES_UNION;
				state_d    = dsuf_pkg::ST_DONE;
			end
			dsuf_pkg::ST_DONE: begin
				done    = 1'b1;
				state_d = dsuf_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/dsuf_dpath.sv =====
module dsuf_dpath #(
	parameter int N_ELEMENTS = dsuf_pkg::N_ELEMENTS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dsuf_pkg::req_t  req,
	input  dsuf_pkg::cmd_t  cmd,
	output dsuf_pkg::stat_t stat,
	output dsuf_pkg::res_t  res
);

	localparam int DEPTH = (N_ELEMENTS < dsuf_pkg::ELEM_COUNT) ?
		N_ELEMENTS : dsuf_pkg::ELEM_COUNT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(N_ELEMENTS);
	localparam int EW    = dsuf_pkg::ELEM_W;
	localparam int SW    = dsuf_pkg::SIZE_W;
	localparam int NW    = dsuf_pkg::NCMP_W;

	localparam logic [NW-1:0] N_L      = NW'(N_ELEMENTS);
	localparam logic [CW-1:0] CNT_LAST = CW'(N_ELEMENTS - 1);
	localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

	logic [EW-1:0] par_mem [DEPTH];
	logic [SW-1:0] size_mem [DEPTH];

	logic [EW-1:0] prd_q;
	logic [SW-1:0] srd_q;
	logic [EW-1:0] a_q, b_q, x_q;
	logic [SW-1:0] sa_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] clr_q;
	dsuf_pkg::res_t res_q, res_d;

	logic [EW-1:0] raddr;
	logic [AW-1:0] pwa, swa;
	logic [EW-1:0] pwd;
	logic [SW-1:0] swd;
	logic          pwe, swe;
	logic          a_big;
	logic [EW-1:0] big, small_e;
	logic [SW:0]   sum;
	logic [SW-1:0] sum_sat;

	always_comb begin
		case (cmd.rsel)
			dsuf_pkg::RD_IN: raddr = req.elem_a;
			dsuf_pkg::RD_A:  raddr = a_q;
			dsuf_pkg::RD_B:  raddr = b_q;
			dsuf_pkg::RD_P:  raddr = prd_q;
			default:         raddr = prd_q;
		endcase
	end

	assign a_big   = !(sa_q < srd_q);
	assign big     = a_big ? a_q : b_q;
	assign small_e = a_big ? b_q : a_q;
	assign sum     = {1'b0, sa_q} + {1'b0, srd_q};
	assign sum_sat = sum[SW] ? dsuf_pkg::SIZE_SAT : sum[SW-1:0];

	always_comb begin
		pwe = cmd.pwe | cmd.clr;
		swe = cmd.swe | cmd.clr;
		if (cmd.clr) begin
			pwa = clr_q;
			pwd = EW'(clr_q);
			swa = clr_q;
			swd = SW'(1);
		end else begin
			swa = big[AW-1:0];
			swd = sum_sat;
			if (cmd.pw_sel == dsuf_pkg::PW_COMP) begin
				pwa = x_q[AW-1:0];
				pwd = res_q.root;
			end else begin
				pwa = small_e[AW-1:0];
				pwd = big;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pwe) begin
			par_mem[pwa] <= pwd;
		end
		prd_q <= par_mem[raddr[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (swe) begin
			size_mem[swa] <= swd;
		end
		srd_q <= size_mem[raddr[AW-1:0]];
	end

	always_comb begin
		res_d = res_q;
		if (cmd.res_ld) begin
			case (cmd.res_op)
				dsuf_pkg::RES_OOR: begin
					res_d.root      = req.elem_a;
					res_d.root_size = SW'(1);
				end
				dsuf_pkg::RES_SZA: begin
					res_d.root      = a_q;
					res_d.root_size = srd_q;
				end
				dsuf_pkg::RES_WALK: begin
					res_d.root      = x_q;
					res_d.root_size = srd_q;
				end
				dsuf_pkg::RES_UNION: begin
					res_d.root      = big;
					res_d.root_size = sum_sat;
				end
				default: res_d = res_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (cmd.load) begin
			a_q <= req.elem_a;
			b_q <= req.elem_b;
		end
		if (cmd.sa_ld) begin
			sa_q <= srd_q;
		end
		if (cmd.load) begin
			x_q <= req.elem_a;
		end else begin
			case (cmd.x_op)
				dsuf_pkg::X_P:    x_q <= prd_q;
				dsuf_pkg::X_A:    x_q <= a_q;
				default:          x_q <= x_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.clr) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	assign stat.a_ok     = NW'(req.elem_a) < N_L;
	assign stat.union_go = (NW'(b_q) < N_L) && (a_q != b_q);
	assign stat.p_root   = prd_q == x_q;
	assign stat.p_oor    = !(NW'(prd_q) < N_L);
	assign stat.cnt_last = cnt_q == CNT_LAST;
	assign stat.x_root   = x_q == res_q.root;
	assign stat.clr_last = clr_q == CLR_LAST;

	assign res = res_q;

endmodule

// ===== sv/dsuf_chk.sv =====
`include "disjoint_set_union_find_defines.svh"

module dsuf_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input dsuf_pkg::res_t res
);

	`DSUF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "no busy after request transfer")
	`DSUF_ASSERT_NOW(a_done_busy, done, busy, "result shown while not busy")
	`DSUF_ASSERT_NEXT(a_done_idle, done, !done && !busy, "result not followed by idle")
	`DSUF_ASSERT_NOW(a_size_nz, done, res.root_size != '0, "zero set size in result")

endmodule

bind disjoint_set_union_find dsuf_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.res    (res)
);

// ===== bench/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N = dsuf_pkg::N_ELEMENTS_DEF;
	localparam int EW = dsuf_pkg::ELEM_W;
	localparam int SW = dsuf_pkg::SIZE_W;
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int QUIET_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 900;

	typedef struct {
		logic [1:0] kind;
		int         a;
		int         b;
		bit         literal;
		int         want_root;
		int         want_size;
	} probe_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	dsuf_pkg::req_t req;
	logic busy;
	logic done;
	dsuf_pkg::res_t res;

	logic [EW-1:0] parent_of [N];
	logic [SW-1:0] set_size [N];
	dsuf_pkg::res_t pending_results [$];
	probe_t probes [24];
	int errors = 0;
	int quiet_cycles = 0;
	int gap_pct = 0;
	bit lit_valid = 1'b0;
	dsuf_pkg::res_t lit_res;

	disjoint_set_union_find #(.N_ELEMENTS(N)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.res(res)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit chase_root(input int e, output int last);
		int x;
		int p;
		x = e;
		for (int steps = 0; steps < N; steps++) begin
			p = parent_of[x];
			if (p == x || p >= N) begin
				last = x;
				return p == x;
			end
			x = p;
		end
		last = x;
		return 1'b0;
	endfunction

	function automatic void flatten(input int e, input int top);
		int x;
		int p;
		int steps;
		x = e;
		steps = 0;
		while (steps < N && x != top) begin
			p = parent_of[x];
			parent_of[x] = EW'(top);
			if (p >= N)
				break;
			x = p;
			steps++;
		end
	endfunction

	function automatic dsuf_pkg::res_t predict_request(input dsuf_pkg::req_t r);
		int a;
		int b;
		int top;
		int big;
		int little;
		int sum;
		int fsize;
		bit found;
		dsuf_pkg::res_t outcome;
		a = r.elem_a;
		b = r.elem_b;
		top = a;
		fsize = 1;
		if (r.kind == dsuf_pkg::KIND_UNION) begin
			if (a < N && b < N) begin
				if (a != b) begin
					big = a;
					little = b;
					if (set_size[a] < set_size[b]) begin
						big = b;
						little = a;
					end
					parent_of[little] = EW'(big);
					sum = int'(set_size[big]) + int'(set_size[little]);
					if (sum > int'(dsuf_pkg::SIZE_SAT))
						sum = int'(dsuf_pkg::SIZE_SAT);
					set_size[big] = SW'(sum);
					top = big;
				end
				fsize = set_size[top];
			end else if (a < N) begin
				fsize = set_size[a];
			end
		end else if (a < N) begin
			found = chase_root(a, top);
			if (found && r.kind == dsuf_pkg::KIND_FIND_C)
				flatten(a, top);
			fsize = set_size[top];
		end
		outcome.root = EW'(top);
		outcome.root_size = SW'(fsize);
		return outcome;
	endfunction

	function automatic dsuf_pkg::req_t pick_request();
		dsuf_pkg::req_t r;
		int rx;
		int ry;
		int roll;
		bit fx;
		bit fy;
		roll = $urandom_range(99);
		r.kind = dsuf_pkg::KIND_FIND;
		r.elem_a = EW'($urandom);
		r.elem_b = EW'($urandom);
		if (roll < 10) begin
			r.kind = 2'($urandom_range(3));
		end else if (roll < 50) begin
			fx = chase_root(r.elem_a, rx);
			fy = chase_root(r.elem_b, ry);
			if (fx && fy) begin
				r.kind = dsuf_pkg::KIND_UNION;
				r.elem_a = EW'(rx);
				r.elem_b = EW'(ry);
			end else begin
				r.kind = dsuf_pkg::KIND_FIND_C;
			end
		end else if (roll < 78) begin
			r.kind = dsuf_pkg::KIND_FIND_C;
		end
		return r;
	endfunction

	task automatic send(input dsuf_pkg::req_t r);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy !== 1'b0);
		@(negedge clk);
		lit_valid = 1'b0;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk) begin
		dsuf_pkg::res_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: result expected none actual root %0d size %0d", $time,
						res.root, res.root_size);
				end else begin
					want = pending_results.pop_front();
					if (res.root !== want.root) begin
						errors++;
						$display("%0t: root expected %0d actual %0d", $time,
							want.root, res.root);
					end
					if (res.root_size !== want.root_size) begin
						errors++;
						$display("%0t: root_size expected %0d actual %0d", $time,
							want.root_size, res.root_size);
					end
				end
			end
			if (start && !busy) begin
				want = predict_request(req);
				pending_results.push_back(lit_valid ? lit_res : want);
			end
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("disjoint_set_union_find verification failed");
				$finish;
			end
		end
	end

	initial begin
		int top;
		int donor;
		start = 1'b0;
		req = '0;
		arst_n = 1'b0;
		for (int i = 0; i < N; i++) begin
			parent_of[i] = EW'(i);
			set_size[i] = SW'(1);
		end
		probes = '{
			'{dsuf_pkg::KIND_FIND_C, 0, 1023, 1, 0, 1},
			'{dsuf_pkg::KIND_FIND, 1023, 0, 1, 1023, 1},
			'{dsuf_pkg::KIND_UNION, 1023, 1023, 1, 1023, 1},
			'{dsuf_pkg::KIND_UNION, 1022, 1023, 1, 1022, 2},
			'{dsuf_pkg::KIND_FIND_C, 1023, 0, 1, 1022, 2},
			'{KIND_SPARE, 1023, 511, 1, 1022, 2},
			'{dsuf_pkg::KIND_UNION, 1021, 1022, 1, 1022, 3},
			'{dsuf_pkg::KIND_UNION, 1020, 1019, 1, 1020, 2},
			'{dsuf_pkg::KIND_UNION, 1020, 1022, 1, 1022, 5},
			'{dsuf_pkg::KIND_UNION, 1018, 1017, 1, 1018, 2},
			'{dsuf_pkg::KIND_UNION, 1016, 1018, 1, 1018, 3},
			'{dsuf_pkg::KIND_UNION, 1018, 1022, 1, 1022, 8},
			'{dsuf_pkg::KIND_FIND, 1017, 0, 0, 0, 0},
			'{dsuf_pkg::KIND_FIND_C, 1017, 1023, 0, 0, 0},
			'{dsuf_pkg::KIND_FIND, 1016, 0, 0, 0, 0},
			'{dsuf_pkg::KIND_UNION, 1020, 1019, 0, 0, 0},
			'{dsuf_pkg::KIND_UNION, 1018, 1020, 0, 0, 0},
			'{dsuf_pkg::KIND_UNION, 1018, 1020, 0, 0, 0},
			'{dsuf_pkg::KIND_UNION, 1018, 1022, 0, 0, 0},
			'{dsuf_pkg::KIND_FIND, 1017, 0, 0, 0, 0},
			'{dsuf_pkg::KIND_FIND_C, 1016, 0, 0, 0, 0},
			'{dsuf_pkg::KIND_FIND_C, 511, 0, 1, 511, 1},
			'{dsuf_pkg::KIND_UNION, 0, 511, 1, 0, 2},
			'{dsuf_pkg::KIND_FIND, 511, 1023, 1, 0, 2}
		};
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		foreach (probes[i]) begin
			lit_valid = probes[i].literal;
			lit_res = '{root: EW'(probes[i].want_root), root_size: SW'(probes[i].want_size)};
			send('{kind: probes[i].kind, elem_a: EW'(probes[i].a), elem_b: EW'(probes[i].b)});
		end

		for (int phase = 0; phase < 4; phase++) begin
			drain();
			case (phase)
				1: gap_pct = 85;
				2: gap_pct = 6;
				default: gap_pct = 0;
			endcase
			repeat (RANDOM_ITEMS / 4)
				send(pick_request());
		end

		// grow the largest root toward the size ceiling by relinking one donor again and again
		drain();
		top = -1;
		for (int i = 0; i < N; i++)
			if (parent_of[i] == i && (top < 0 || set_size[i] > set_size[top]))
				top = i;
		donor = -1;
		if (top >= 0)
			for (int i = 0; i < N; i++)
				if (i != top && set_size[i] <= set_size[top] &&
						(donor < 0 || set_size[i] > set_size[donor]))
					donor = i;
		if (donor >= 0) begin
			for (int k = 0; k < 400 && set_size[top] != dsuf_pkg::SIZE_SAT; k++)
				send('{kind: dsuf_pkg::KIND_UNION, elem_a: EW'(top), elem_b: EW'(donor)});
			repeat (3)
				send('{kind: dsuf_pkg::KIND_UNION, elem_a: EW'(top), elem_b: EW'(donor)});
		end

		drain();
		repeat (64) @(negedge clk);
		if (pending_results.size() != 0) begin
			errors++;
			$display("%0t: results expected 0 pending actual %0d", $time,
				pending_results.size());
		end
		if (errors == 0)
			$display("disjoint_set_union_find verification clean");
		else
			$display("disjoint_set_union_find verification failed");
		$finish;
	end

endmodule
